### sv/pel_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine package
// Shared widths, codes, word types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package pel_pkg;

   localparam int DEFAULT_CAPACITY = 64;
   localparam int POS_W            = 7;
   localparam int VAL_W            = 32;
   localparam int KIND_W           = 2;
   localparam int STATUS_W         = 2;

   localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REVERSE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

   localparam logic [VAL_W-1:0] ERR_VALUE = {VAL_W{1'b1}};

   typedef struct packed {
      logic [KIND_W-1:0]       kind;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] removed_value;
      logic [STATUS_W-1:0]     status;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic check;
      logic set_ins_idx;
      logic set_rem_idx;
      logic set_rev;
      logic shift_rd;
      logic idx_dec;
      logic idx_inc;
      logic wr_value;
      logic cnt_inc;
      logic cnt_dec;
      logic rev_rd_lo;
      logic rev_rd_hi;
      logic rev_wr_hi;
      logic rev_wr_lo;
      logic res_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              err;
      logic              ins_at_end;
      logic              idx_at_pos;
      logic              idx_at_last;
      logic              rev_small;
      logic              rev_more;
      logic              rsp_free;
   } stat_type;

endpackage

### sv/pel_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module pel_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/pel_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine datapath
// Entry memory, count, index pointers, error check and the result register.
// ----------------------------------------------------------------------------
module pel_datapath import pel_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_payload,
   input  logic     rsp_stall,
   output logic     rsp_valid,
   output rsp_type  rsp_payload,
   input  cmd_type  cmd,
   output stat_type stat
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;
   localparam int DW = AW + 1;

   // Request fields held for the whole operation.
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [VAL_W-1:0]    value_ff, value_in;

   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [AW-1:0]       lo_ff, lo_in;
   logic [AW-1:0]       hi_ff, hi_in;
   logic                pend_ff, pend_in;
   logic [AW-1:0]       src_ff, src_in;
   logic [VAL_W-1:0]    tmp_a_ff, tmp_a_in;
   logic [VAL_W-1:0]    tmp_b_ff, tmp_b_in;
   logic [STATUS_W-1:0] code_ff, code_in;
   logic [VAL_W-1:0]    removed_ff, removed_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [STATUS_W-1:0] code;
   logic [XW-1:0]       pos_x;
   logic [XW-1:0]       count_x;
   logic [AW-1:0]       pos_a;
   logic [AW-1:0]       last_a;
   logic [DW-1:0]       span;
   logic                cap_now;

   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [VAL_W-1:0]    ram_wr_data;
   logic [AW-1:0]       ram_rd_addr;
   logic [VAL_W-1:0]    ram_rd_data;

   assign pos_x   = XW'(pos_ff);
   assign count_x = XW'(count_ff);
   assign pos_a   = AW'(pos_ff);
   assign last_a  = AW'(count_ff - 1'b1);
   assign span    = {1'b0, hi_ff} - {1'b0, lo_ff};

   // A pending read at the remove position is the removed value, not a move.
   assign cap_now = pend_ff && (kind_ff == KIND_REMOVE) && (src_ff == pos_a);

   always_comb begin
      code = ST_OK;
      unique case (kind_ff)
         KIND_INSERT: begin
            if (pos_x > count_x) begin
               code = ST_RANGE;
            end else if (count_ff == CW'(CAPACITY)) begin
               code = ST_FULL;
            end
         end
         KIND_REMOVE: begin
            if (count_ff == '0) begin
               code = ST_EMPTY;
            end else if (pos_x >= count_x) begin
               code = ST_RANGE;
            end
         end
         KIND_REVERSE: begin
            code = ST_OK;
         end
         default: begin
            code = ST_RANGE;
         end
      endcase
   end

   // Memory port steering.
   always_comb begin
      if (cmd.rev_rd_lo) begin
         ram_rd_addr = lo_ff;
      end else if (cmd.rev_rd_hi) begin
         ram_rd_addr = hi_ff;
      end else begin
         ram_rd_addr = idx_ff;
      end

      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = ram_rd_data;
      if (pend_ff && !cap_now) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = (kind_ff == KIND_INSERT) ? AW'(src_ff + 1'b1) : AW'(src_ff - 1'b1);
         ram_wr_data = ram_rd_data;
      end else if (cmd.wr_value) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = pos_a;
         ram_wr_data = value_ff;
      end else if (cmd.rev_wr_hi) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = hi_ff;
         ram_wr_data = tmp_a_ff;
      end else if (cmd.rev_wr_lo) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = lo_ff;
         ram_wr_data = tmp_b_ff;
      end
   end

   pel_ram #(
      .WIDTH (VAL_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next-state logic for the datapath registers.
   always_comb begin
      kind_in      = kind_ff;
      pos_in       = pos_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      pend_in      = cmd.shift_rd;
      src_in       = src_ff;
      tmp_a_in     = tmp_a_ff;
      tmp_b_in     = tmp_b_ff;
      code_in      = code_ff;
      removed_in   = removed_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (cmd.load_req) begin
         kind_in  = req_payload.kind;
         pos_in   = req_payload.position;
         value_in = req_payload.item_value;
      end
      if (cmd.check) begin
         code_in = code;
      end
      if (cmd.set_ins_idx) begin
         idx_in = last_a;
      end else if (cmd.set_rem_idx) begin
         idx_in = pos_a;
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - 1'b1;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.shift_rd) begin
         src_in = idx_ff;
      end
      if (cap_now) begin
         removed_in = ram_rd_data;
      end
      if (cmd.cnt_inc) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - 1'b1;
      end
      if (cmd.set_rev) begin
         lo_in = '0;
         hi_in = last_a;
      end else if (cmd.rev_wr_lo) begin
         lo_in = lo_ff + 1'b1;
         hi_in = hi_ff - 1'b1;
      end
      if (cmd.rev_rd_hi) begin
         tmp_a_in = ram_rd_data;
      end
      if (cmd.rev_wr_hi) begin
         tmp_b_in = ram_rd_data;
      end

      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
         rsp_in.status = code_ff;
         if (code_ff != ST_OK) begin
            rsp_in.removed_value = ERR_VALUE;
         end else if (kind_ff == KIND_REMOVE) begin
            rsp_in.removed_value = removed_ff;
         end else begin
            rsp_in.removed_value = '0;
         end
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      pos_ff     <= pos_in;
      value_ff   <= value_in;
      idx_ff     <= idx_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      src_ff     <= src_in;
      tmp_a_ff   <= tmp_a_in;
      tmp_b_ff   <= tmp_b_in;
      code_ff    <= code_in;
      removed_ff <= removed_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign stat.kind        = kind_ff;
   assign stat.err         = (code != ST_OK);
   assign stat.ins_at_end  = (pos_x == count_x);
   assign stat.idx_at_pos  = (idx_ff == pos_a);
   assign stat.idx_at_last = (idx_ff == last_a);
   assign stat.rev_small   = (count_ff < CW'(2));
   assign stat.rev_more    = (span > DW'(2));
   assign stat.rsp_free    = !rsp_valid_ff || !rsp_stall;

endmodule

### sv/pel_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine controller
// Sequences the check, shift, reverse and result steps of one request.
// ----------------------------------------------------------------------------
module pel_controller import pel_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_CHECK     = 4'd1;
   localparam logic [3:0] S_INS_SHIFT = 4'd2;
   localparam logic [3:0] S_INS_DRAIN = 4'd3;
   localparam logic [3:0] S_WRITE_VAL = 4'd4;
   localparam logic [3:0] S_REM_SHIFT = 4'd5;
   localparam logic [3:0] S_REM_DRAIN = 4'd6;
   localparam logic [3:0] S_REV_RD_LO = 4'd7;
   localparam logic [3:0] S_REV_RD_HI = 4'd8;
   localparam logic [3:0] S_REV_WR_HI = 4'd9;
   localparam logic [3:0] S_REV_WR_LO = 4'd10;
   localparam logic [3:0] S_FINISH    = 4'd11;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (stat.err) begin
               state_in = S_FINISH;
            end else if (stat.kind == KIND_INSERT) begin
               if (stat.ins_at_end) begin
                  state_in = S_WRITE_VAL;
               end else begin
                  cmd.set_ins_idx = 1'b1;
                  state_in        = S_INS_SHIFT;
               end
            end else if (stat.kind == KIND_REMOVE) begin
               cmd.set_rem_idx = 1'b1;
               state_in        = S_REM_SHIFT;
            end else if (stat.rev_small) begin
               state_in = S_FINISH;
            end else begin
               cmd.set_rev = 1'b1;
               state_in    = S_REV_RD_LO;
            end
         end
         S_INS_SHIFT: begin
            cmd.shift_rd = 1'b1;
            if (stat.idx_at_pos) begin
               state_in = S_INS_DRAIN;
            end else begin
               cmd.idx_dec = 1'b1;
            end
         end
         S_INS_DRAIN: begin
            state_in = S_WRITE_VAL;
         end
         S_WRITE_VAL: begin
            cmd.wr_value = 1'b1;
            cmd.cnt_inc  = 1'b1;
            state_in     = S_FINISH;
         end
         S_REM_SHIFT: begin
            cmd.shift_rd = 1'b1;
            if (stat.idx_at_last) begin
               state_in = S_REM_DRAIN;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_REM_DRAIN: begin
            cmd.cnt_dec = 1'b1;
            state_in    = S_FINISH;
         end
         S_REV_RD_LO: begin
            cmd.rev_rd_lo = 1'b1;
            state_in      = S_REV_RD_HI;
         end
         S_REV_RD_HI: begin
            cmd.rev_rd_hi = 1'b1;
            state_in      = S_REV_WR_HI;
         end
         S_REV_WR_HI: begin
            cmd.rev_wr_hi = 1'b1;
            state_in      = S_REV_WR_LO;
         end
         S_REV_WR_LO: begin
            cmd.rev_wr_lo = 1'b1;
            state_in      = stat.rev_more ? S_REV_RD_LO : S_FINISH;
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/positional_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed 32-bit values with insert, remove and reverse.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Word
//   req_     in         req_valid / req_stall  kind, position, item_value
//   rsp_     out        rsp_valid / rsp_stall  removed_value, status
//
// One request is worked on at a time. An insert moves the entries from the
// requested position up by one slot (none when it appends at the end), a
// remove moves those above the position down, a reverse swaps pairs from
// both ends inward and a rejected request ends after its check. The entry
// memory has a single read and a single write port: every moved entry costs
// one read and one write, and a reverse costs two of each per swapped pair.
// Reset clears the count and the control state; the entry memory is not
// cleared, since only entries below the count are ever read.
// A stalled result waits in its output register while the next request is
// accepted and worked on; that request finishes once the register is free.
//
// ----------------------------------------------------------------------------
module positional_list_engine import pel_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   // The controller only decides which step runs next; all data storage, the
   // range checks and the result register live in the datapath.
   cmd_type  cmd;
   stat_type stat;

   pel_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Shifts use a delayed write: each entry read is written to its neighbor in
   // the next cycle while the following read goes out.
   pel_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

### test/tb_positional_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Drives insert, remove and reverse words into the list engine under random
// sender gaps and receiver stalls. A list model inside the bench works out
// the result for every accepted word. Each returned word is checked against
// the oldest expected result.
// ----------------------------------------------------------------------------
module tb_positional_list_engine;
   import pel_pkg::*;

   localparam int CAPACITY    = DEFAULT_CAPACITY;
   // The slowest word is a reverse of a full list. With receiver stalls and
   // sender gaps on top, 1400 words stay well under a third of this limit.
   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAIL_CYCLES = 2 * CAPACITY + 16;

   // The kind code that the block does not use. It must still answer with a
   // range error.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_HALF,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   // All inputs of the block start at known values.
   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   // Bench copy of the list. Slots below list_len hold the entries, front first.
   logic signed [VAL_W-1:0] list_slots [CAPACITY];
   int list_len = 0;
   int peak_len = 0;

   // Results still owed by the block, oldest first.
   rsp_type pending_results[$];

   int error_count  = 0;
   int words_sent   = 0;
   int results_seen = 0;
   int burst_left   = 0;
   int unsigned cycle_count = 0;

   stall_mode_type stall_mode = STALL_NONE;
   int stall_left = 0;

   positional_list_engine #(.CAPACITY(CAPACITY)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // List model. The function applies one accepted word to the bench copy of
   // the list and returns the result word the block must give back. The
   // order of the error checks matters. For an insert, a bad position is
   // reported before a full list. For a remove, an empty list is reported
   // before a bad position.
   // ------------------------------------------------------------------------
   function automatic rsp_type apply_request(req_type w);
      rsp_type r;
      int pos;
      int k;
      logic signed [VAL_W-1:0] swap;
      pos             = int'(w.position);
      r.removed_value = ERR_VALUE;
      r.status        = ST_RANGE;
      case (w.kind)
         KIND_INSERT: begin
            if (pos > list_len) begin
               r.status = ST_RANGE;
            end else if (list_len >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               for (k = list_len; k > pos; k--) begin
                  list_slots[k] = list_slots[k - 1];
               end
               list_slots[pos] = w.item_value;
               list_len++;
               r.removed_value = '0;
               r.status        = ST_OK;
            end
         end
         KIND_REMOVE: begin
            if (list_len == 0) begin
               r.status = ST_EMPTY;
            end else if (pos >= list_len) begin
               r.status = ST_RANGE;
            end else begin
               r.removed_value = list_slots[pos];
               r.status        = ST_OK;
               for (k = pos; k + 1 < list_len; k++) begin
                  list_slots[k] = list_slots[k + 1];
               end
               list_len--;
            end
         end
         KIND_REVERSE: begin
            for (k = 0; k < list_len / 2; k++) begin
               swap                          = list_slots[k];
               list_slots[k]                 = list_slots[list_len - 1 - k];
               list_slots[list_len - 1 - k]  = swap;
            end
            r.removed_value = '0;
            r.status        = ST_OK;
         end
         default: begin
            // The unused kind changes nothing and keeps the range error set above.
         end
      endcase
      if (list_len > peak_len) begin
         peak_len = list_len;
      end
      return r;
   endfunction

   // Values lean toward the signed extremes, zero and all ones. The rest
   // are fully random, so every bit of the field is set and cleared.
   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Sender. This task is always entered at a rising edge. It may first open
   // a gap, which ends the current burst. Then it holds the word until the
   // block takes it. The list model is updated at the edge that accepts the
   // word. Valid is left high on return so that back-to-back words go out
   // without a bubble. Only a gap or a drain lowers valid, and both wait for
   // the clock before valid can rise again.
   // ------------------------------------------------------------------------
   task automatic send_word(input logic [KIND_W-1:0] kind, input int position,
                            input logic signed [VAL_W-1:0] value);
      req_type w;
      int gap;
      w.kind       = kind;
      w.position   = position[POS_W-1:0];
      w.item_value = value;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= w;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(apply_request(w));
      words_sent++;
   endtask

   // The sender holds off until the block has returned every result it owes.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // ------------------------------------------------------------------------
   // Test: edge cases on a short list. These words cover empty-list removes,
   // a remove from an empty list at a huge position, and a reverse of zero
   // and of one entry. They insert at the front, at the end and in the
   // middle, including at positions past the count. They remove at the
   // count itself and at the top position code, and use the unused kind. The
   // sequence ends by removing the sole entry and checking that the list
   // still works.
   // ------------------------------------------------------------------------
   task automatic test_directed_edges();
      send_word(KIND_REMOVE, 0, 32'sh0);
      send_word(KIND_REMOVE, 127, 32'sh7FFF_FFFF);
      send_word(KIND_REVERSE, 0, 32'sh0);
      send_word(KIND_INSERT, 1, 32'sh0000_0005);
      send_word(KIND_INSERT, 0, 32'sh7FFF_FFFF);
      send_word(KIND_REVERSE, 0, 32'sh0);
      send_word(KIND_INSERT, 1, 32'sh8000_0000);
      send_word(KIND_INSERT, 0, -32'sd1);
      send_word(KIND_INSERT, 1, 32'sh0);
      send_word(KIND_INSERT, 127, 32'sh5555_5555);
      send_word(KIND_UNUSED, 0, 32'shAAAA_AAAA);
      send_word(KIND_UNUSED, 127, -32'sd1);
      send_word(KIND_REVERSE, 127, 32'sh0);
      send_word(KIND_REMOVE, list_len, 32'sh0);
      send_word(KIND_REMOVE, 127, 32'sh0);
      send_word(KIND_REMOVE, 0, 32'sh0);
      send_word(KIND_REMOVE, list_len - 1, 32'sh0);
      send_word(KIND_INSERT, list_len, 32'sh1234_5678);
      send_word(KIND_REMOVE, 1, 32'sh0);
      send_word(KIND_REMOVE, 0, 32'sh0);
      send_word(KIND_REMOVE, 0, 32'sh0);
      send_word(KIND_REMOVE, 0, 32'sh0);
      send_word(KIND_INSERT, 0, 32'shDEAD_BEEF);
      send_word(KIND_REMOVE, 0, 32'sh0);
   endtask

   // ------------------------------------------------------------------------
   // Test: the list at capacity. The list is filled with inserts at random
   // positions. Then a full list gets inserts at the front and at the end
   // (full error) and past the end (range error, which wins over full). It is
   // reversed whole and its last slot is removed and refilled. Finally it is
   // drained to empty with the odd reverse mixed in.
   // ------------------------------------------------------------------------
   task automatic test_full_list();
      while (list_len < CAPACITY) begin
         send_word(KIND_INSERT, $urandom_range(0, list_len), pick_value());
      end
      send_word(KIND_INSERT, 0, pick_value());
      send_word(KIND_INSERT, CAPACITY, pick_value());
      send_word(KIND_INSERT, CAPACITY + 1, pick_value());
      send_word(KIND_INSERT, 127, pick_value());
      send_word(KIND_REVERSE, 0, pick_value());
      send_word(KIND_REMOVE, CAPACITY, 32'sh0);
      send_word(KIND_REMOVE, CAPACITY - 1, 32'sh0);
      send_word(KIND_INSERT, CAPACITY - 1, pick_value());
      send_word(KIND_REVERSE, 0, 32'sh0);
      while (list_len > 0) begin
         if ($urandom_range(0, 9) == 0) begin
            send_word(KIND_REVERSE, $urandom_range(0, 127), pick_value());
         end else begin
            send_word(KIND_REMOVE, $urandom_range(0, list_len - 1), pick_value());
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Test: random traffic. Most words are well formed: inserts at a legal
   // position, with the front and the end favored, removes at a legal
   // position, and reverses. The rest are noise with a random kind and any
   // position code. grow_pct sets how often an insert is chosen over a
   // remove. A high value drives the list to capacity and keeps it there,
   // and a low value keeps it short and often empty.
   // ------------------------------------------------------------------------
   task automatic test_random_mix(input int words, input int grow_pct);
      int n;
      int roll;
      logic [KIND_W-1:0] noise_kind;
      for (n = 0; n < words; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            noise_kind = KIND_W'($urandom_range(0, 3));
            send_word(noise_kind, $urandom_range(0, 127), pick_value());
         end else if (roll < 20) begin
            send_word(KIND_REVERSE, $urandom_range(0, 127), pick_value());
         end else if (list_len == 0 || $urandom_range(0, 99) < grow_pct) begin
            case ($urandom_range(0, 3))
               0:       send_word(KIND_INSERT, 0, pick_value());
               1:       send_word(KIND_INSERT, list_len, pick_value());
               default: send_word(KIND_INSERT, $urandom_range(0, list_len), pick_value());
            endcase
         end else begin
            case ($urandom_range(0, 3))
               0:       send_word(KIND_REMOVE, 0, pick_value());
               1:       send_word(KIND_REMOVE, list_len - 1, pick_value());
               default: send_word(KIND_REMOVE, $urandom_range(0, list_len - 1),
                                  pick_value());
            endcase
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Receiver. Stall behavior switches between randomly picked modes.
   // Modes are no stall at all, a coin flip, mostly stalled, and a fixed
   // pattern. Stalls therefore hit results at every stage of the block's
   // work, and some long stretches never stall.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 200);
      end
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_HALF:     rsp_stall <= ($urandom_range(0, 1) == 1);
         STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 4) != 0);
         STALL_PERIODIC: rsp_stall <= ((stall_left % 5) < 2);
         default:        rsp_stall <= 1'b0;
      endcase
      stall_left--;
   end

   // ------------------------------------------------------------------------
   // Result checker. A result word is taken at an edge where valid is high and
   // stall is low. Both are read before that edge updates anything. The word
   // is compared field by field with the oldest expected result.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("unexpected result word: removed_value %0d, status %0d",
                   rsp_payload.removed_value, rsp_payload.status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.removed_value !== want.removed_value) begin
               $error("removed_value: expected %0d, got %0d",
                      want.removed_value, rsp_payload.removed_value);
               error_count++;
            end
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
               error_count++;
            end
         end
      end
   end

   // Watchdog. A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed",
                  cycle_count, pending_results.size());
         $display("tb_positional_list_engine: done, errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence. Reset is held high at the start and then released for good.
   // Between most of the phases the sender waits for every owed result, so
   // the block is seen idle with a non-empty list as well.
   // ------------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_edges();
      test_full_list();
      wait_drained();
      test_random_mix(350, 70);
      wait_drained();
      test_random_mix(300, 30);
      test_random_mix(300, 55);
      wait_drained();
      test_random_mix(250, 45);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d request words and %0d result words; list peaked at %0d of %0d",
               words_sent, results_seen, peak_len, CAPACITY);
      $display("mismatches and stray results counted: %0d", error_count);
      if (error_count == 0) begin
         $display("tb_positional_list_engine: done, clean");
      end else begin
         $display("tb_positional_list_engine: done, errors");
      end
      $finish;
   end

endmodule

### filelist.f
sv/pel_pkg.sv
sv/pel_ram.sv
sv/pel_datapath.sv
sv/pel_controller.sv
sv/positional_list_engine.sv
test/tb_positional_list_engine.sv
